// ----- rtl/core/kti_pkg.sv -----
package kti_pkg;

    localparam int MAX_KEYS  = 16;
    localparam int KEY_AW    = $clog2(MAX_KEYS);
    localparam int VAL_W     = 32;
    localparam int FRAC_BITS = 16;
    localparam int DIV_CW    = $clog2(FRAC_BITS);
    localparam int NUM_COMP  = 3;
    localparam int COMP_W    = $clog2(NUM_COMP);
    localparam int KC_W      = 5;
    localparam int SLOT_W    = 4;

    localparam int S_FIELDS_W = SLOT_W + 5 * VAL_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int S_TUSER_W  = 1;
    localparam int M_TDATA_W  = NUM_COMP * VAL_W;
    localparam int M_TUSER_W  = 2;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [APB_AW-3:0] REG_KEY_COUNT = '0;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_BEFORE = 2'd1,
        STAT_AFTER  = 2'd2,
        STAT_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIRST,
        ST_SEARCH,
        ST_CHECK,
        ST_DIV,
        ST_SUB,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [VAL_W-1:0] key_time;
        logic [VAL_W-1:0] x;
        logic [VAL_W-1:0] y;
        logic [VAL_W-1:0] z;
    } key_entry_t;

    typedef struct packed {
        logic [VAL_W-1:0] x;
        logic [VAL_W-1:0] y;
        logic [VAL_W-1:0] z;
        status_t          status;
    } result_t;

endpackage

// ----- rtl/core/keyframe_track_interpolator.sv -----
// Keyframe track interpolator. Key writes (tuser op 0) store a time and an xyz vector into
// one of 16 table slots and return an all-zero item; queries (op 1) search the table
// linearly for the first key later than the query time and return the linear blend of the
// two surrounding keys, or a clamped key with a status code. One item is in work at a time.
// A query's work is made of the one-key-per-cycle read of the single key RAM read port,
// the 16-step restoring divider for the Q0.16 factor and the one shared multiplier used
// for x, y and z in turn. The result is held in an output register, so a stalled master
// side costs nothing until the next result is ready. key_count is written through the
// APB port at address 0.
module keyframe_track_interpolator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // key_slot[3:0], key_time[35:4], value_x[67:36], value_y[99:68], value_z[131:100],
    // query_time[163:132], zero pad above
    input  logic [kti_pkg::S_TDATA_W-1:0]  s_tdata,
    // op[0]
    input  logic [kti_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64]
    output logic [kti_pkg::M_TDATA_W-1:0]  m_tdata,
    // status[1:0]
    output logic [kti_pkg::M_TUSER_W-1:0]  m_tuser,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [kti_pkg::APB_AW-1:0]     paddr,
    input  logic [kti_pkg::APB_DW-1:0]     pwdata,
    output logic [kti_pkg::APB_DW-1:0]     prdata,
    output logic                           pready
);
    import kti_pkg::*;

    state_t              state_reg, state_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [KC_W-1:0]     key_count_reg;
    result_t             out_reg, out_next;
    result_t             res_reg, res_next;
    key_entry_t          prev_reg, prev_next;
    key_entry_t          cur_reg, cur_next;
    logic [VAL_W-1:0]    q_reg, q_next;
    logic [KEY_AW-1:0]   n_last_reg, n_last_next;
    logic [KEY_AW-1:0]   idx_reg, idx_next;
    logic [VAL_W-1:0]    rem_reg, rem_next;
    logic [VAL_W-1:0]    delta_reg, delta_next;
    logic [FRAC_BITS-1:0] quot_reg, quot_next;
    logic [DIV_CW-1:0]   cnt_reg, cnt_next;
    logic [COMP_W-1:0]   comp_reg, comp_next;
    logic signed [VAL_W:0] d_reg, d_next;
    logic signed [FRAC_BITS+VAL_W+1:0] prod_reg, prod_next;

    logic                s_accept;
    logic                in_op;
    logic [SLOT_W-1:0]   in_slot;
    key_entry_t          in_entry;
    logic [VAL_W-1:0]    in_query;
    logic                ram_we;
    key_entry_t          rd_entry;
    logic [KEY_AW-1:0]   n_last_cfg;
    logic [VAL_W:0]      rem2;
    logic [VAL_W:0]      delta_ext;
    logic                div_ge;
    logic [VAL_W-1:0]    start_c;
    logic [VAL_W-1:0]    end_c;
    logic [VAL_W-1:0]    sum_c;
    logic                cfg_wr;

    assign in_op             = s_tuser[0];
    assign in_slot           = s_tdata[3:0];
    assign in_entry.key_time = s_tdata[35:4];
    assign in_entry.x        = s_tdata[67:36];
    assign in_entry.y        = s_tdata[99:68];
    assign in_entry.z        = s_tdata[131:100];
    assign in_query          = s_tdata[163:132];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign ram_we   = s_accept && (in_op == OP_WRITE) && (int'(in_slot) < MAX_KEYS);

    kti_ram #(
        .WIDTH ($bits(key_entry_t)),
        .DEPTH (MAX_KEYS)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (KEY_AW'(in_slot)),
        .wdata (in_entry),
        .raddr (idx_next),
        .rdata (rd_entry)
    );

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_KEY_COUNT);
    assign prdata = (paddr[APB_AW-1:2] == REG_KEY_COUNT) ?
                    APB_DW'(key_count_reg) : '0;

    always_comb
    begin
        if (key_count_reg == '0)
        begin
            n_last_cfg = '0;
        end
        else if (int'(key_count_reg) > MAX_KEYS)
        begin
            n_last_cfg = KEY_AW'(MAX_KEYS - 1);
        end
        else
        begin
            n_last_cfg = KEY_AW'(key_count_reg - KC_W'(1));
        end
    end

    assign rem2      = {rem_reg, 1'b0};
    assign delta_ext = {1'b0, delta_reg};
    assign div_ge    = (rem2 >= delta_ext);

    always_comb
    begin
        case (comp_reg)
            COMP_W'(0):
            begin
                start_c = prev_reg.x;
                end_c   = cur_reg.x;
            end
            COMP_W'(1):
            begin
                start_c = prev_reg.y;
                end_c   = cur_reg.y;
            end
            default:
            begin
                start_c = prev_reg.z;
                end_c   = cur_reg.z;
            end
        endcase
    end

    assign sum_c = start_c + prod_reg[FRAC_BITS+VAL_W-1:FRAC_BITS];

    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        out_next      = out_reg;
        res_next      = res_reg;
        prev_next     = prev_reg;
        cur_next      = cur_reg;
        q_next        = q_reg;
        n_last_next   = n_last_reg;
        idx_next      = idx_reg;
        rem_next      = rem_reg;
        delta_next    = delta_reg;
        quot_next     = quot_reg;
        cnt_next      = cnt_reg;
        comp_next     = comp_reg;
        d_next        = d_reg;
        prod_next     = prod_reg;

        case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (s_accept)
                begin
                    if (in_op == OP_WRITE)
                    begin
                        res_next   = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        q_next      = in_query;
                        n_last_next = n_last_cfg;
                        state_next  = ST_FIRST;
                    end
                end
            end
            ST_FIRST:
            begin
                prev_next = rd_entry;
                res_next  = {rd_entry.x, rd_entry.y, rd_entry.z, STAT_OK};
                if (n_last_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else if (q_reg < rd_entry.key_time)
                begin
                    res_next.status = STAT_BEFORE;
                    state_next      = ST_DONE;
                end
                else
                begin
                    idx_next   = KEY_AW'(1);
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (q_reg < rd_entry.key_time)
                begin
                    cur_next   = rd_entry;
                    state_next = ST_CHECK;
                end
                else if (idx_reg == n_last_reg)
                begin
                    res_next   = {rd_entry.x, rd_entry.y, rd_entry.z, STAT_AFTER};
                    state_next = ST_DONE;
                end
                else
                begin
                    prev_next = rd_entry;
                    idx_next  = idx_reg + KEY_AW'(1);
                end
            end
            ST_CHECK:
            begin
                res_next = {prev_reg.x, prev_reg.y, prev_reg.z, STAT_OK};
                if (cur_reg.key_time <= prev_reg.key_time)
                begin
                    res_next.status = STAT_EMPTY;
                    state_next      = ST_DONE;
                end
                else if (q_reg < prev_reg.key_time)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    rem_next   = q_reg - prev_reg.key_time;
                    delta_next = cur_reg.key_time - prev_reg.key_time;
                    quot_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_ge)
                begin
                    rem_next = VAL_W'(rem2 - delta_ext);
                end
                else
                begin
                    rem_next = VAL_W'(rem2);
                end
                quot_next = {quot_reg[FRAC_BITS-2:0], div_ge};
                cnt_next  = cnt_reg + DIV_CW'(1);
                if (cnt_reg == DIV_CW'(FRAC_BITS - 1))
                begin
                    comp_next  = '0;
                    state_next = ST_SUB;
                end
            end
            ST_SUB:
            begin
                d_next     = $signed({end_c[VAL_W-1], end_c}) -
                             $signed({start_c[VAL_W-1], start_c});
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = $signed({1'b0, quot_reg}) * d_reg;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                case (comp_reg)
                    COMP_W'(0): res_next.x = sum_c;
                    COMP_W'(1): res_next.y = sum_c;
                    default:    res_next.z = sum_c;
                endcase
                res_next.status = STAT_OK;
                if (comp_reg == COMP_W'(NUM_COMP - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    comp_next  = comp_reg + COMP_W'(1);
                    state_next = ST_SUB;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_next      = res_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            m_tvalid_reg  <= 1'b0;
            key_count_reg <= KC_W'(1);
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr)
            begin
                key_count_reg <= pwdata[KC_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg    <= out_next;
        res_reg    <= res_next;
        prev_reg   <= prev_next;
        cur_reg    <= cur_next;
        q_reg      <= q_next;
        n_last_reg <= n_last_next;
        idx_reg    <= idx_next;
        rem_reg    <= rem_next;
        delta_reg  <= delta_next;
        quot_reg   <= quot_next;
        cnt_reg    <= cnt_next;
        comp_reg   <= comp_next;
        d_reg      <= d_next;
        prod_reg   <= prod_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_reg.z, out_reg.y, out_reg.x};
    assign m_tuser  = out_reg.status;

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> (state_reg == ST_FIRST || state_reg == ST_DONE))
        else $error("accepted item did not start work");

    a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < delta_reg))
        else $error("divider remainder out of range");

    a_search_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (idx_reg <= n_last_reg && idx_reg != '0))
        else $error("search index beyond valid keys");

    a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && (!m_tvalid_reg || m_tready)) |=>
        (m_tvalid_reg && state_reg == ST_IDLE))
        else $error("finished result not presented");

endmodule

// ----- rtl/core/kti_ram.sv -----
module kti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
